@@ rtl/hmt_pkg.sv @@
// Shared types and codes for the histogram median tracker.
`default_nettype none
package hmt_pkg;
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MEDIAN = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OUTW  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic CFG_LOWEST = 1'b0;
  localparam logic CFG_BINCNT = 1'b1;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [15:0] value;
    logic        in_window;
    logic [16:0] offset;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/hmt_front.sv @@
// Front end: accepts input transfers, classifies them and queues them.
`default_nettype none
module hmt_front import hmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,
  input  wire logic [15:0] in_tdata,
  input  wire logic [15:0] lowest_r,
  input  wire logic [16:0] used_bins,
  output logic             q_valid,
  input  wire logic        q_pop,
  output cmd_t             q_cmd
);
  // Two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [17:0] off;
  cmd_t       cmd;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign off       = 18'($signed({{2{in_tdata[15]}}, in_tdata}) -
                         $signed({{2{lowest_r[15]}}, lowest_r}));

  // Window test on the signed offset
  always_comb begin
    cmd.op        = op_t'(in_tuser);
    cmd.value     = in_tdata;
    cmd.offset    = off[16:0];
    cmd.in_window = !off[17] && (off[16:0] < used_bins);
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_tready) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

@@ rtl/hmt_back.sv @@
// Back end: bin memory, statistics, median scan, clear sweep, result register.
`default_nettype none
module hmt_back import hmt_pkg::*; #(
  parameter int BINS = 1024,
  localparam int AW = $clog2(BINS)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  cmd_t             q_cmd,
  input  wire logic        cfg_fire,
  input  wire logic [15:0] lowest_r,
  input  wire logic [16:0] used_bins,
  input  wire logic [15:0] wtop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,
  output logic [87:0]      out_tdata
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_WR, S_SCAN, S_OUT
  } state_t;

  state_t       st_r;
  logic [31:0]  mem [BINS];
  logic [31:0]  rd_r;
  logic [AW-1:0] addr_r;
  logic [AW:0]  idx_r;
  logic [32:0]  cum_r;
  logic [31:0]  tot_r;
  logic [15:0]  min_r, max_r;
  logic [AW:0]  lo_r;
  logic         lo_ok_r;
  logic [32:0]  rlo_r, rhi_r;
  cmd_t         cmd_r;
  logic [1:0]   stat_r;
  logic [16:0]  med_r;
  logic         ov_r;
  logic [32:0]  cum_n;
  logic         last;

  assign q_pop = (st_r == S_IDLE) && q_valid && !ov_r;
  assign cum_n = cum_r + {1'b0, rd_r};
  assign last  = ({{(16-AW){1'b0}}, idx_r} + 17'd1) >= used_bins;
  assign out_tvalid = ov_r;
  assign out_tuser  = stat_r;
  assign out_tdata  = {7'd0, max_r, min_r, tot_r, med_r};

  always_ff @(posedge clk) begin
    rd_r <= mem[addr_r];
    if ((st_r == S_CLR) || (st_r == S_WR && cmd_r.op == OP_INSERT))
      mem[addr_r] <= (st_r == S_CLR) ? 32'd0 : rd_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_fire) begin
      st_r   <= S_CLR;
      addr_r <= '0;
      ov_r   <= 1'b0;
      stat_r <= ST_DONE;
      tot_r  <= '0;
      min_r  <= wtop;
      max_r  <= lowest_r;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (st_r)
        // sweep zeros through every bin
        S_CLR: begin
          addr_r <= addr_r + AW'(1);
          tot_r  <= '0;
          min_r  <= wtop;
          max_r  <= lowest_r;
          if (addr_r == AW'(BINS - 1)) begin
            st_r <= (cmd_r.op == OP_CLEAR && ov_r == 1'b0 && stat_r == ST_FULL) ?
                    S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r  <= q_cmd;
            addr_r <= AW'(q_cmd.offset);
            med_r  <= '0;
            stat_r <= ST_DONE;
            case (q_cmd.op)
              OP_INSERT: begin
                if (!q_cmd.in_window) begin
                  stat_r <= ST_OUTW; st_r <= S_OUT;
                end else if (tot_r == 32'hFFFF_FFFF) begin
                  stat_r <= ST_FULL; st_r <= S_OUT;
                end else st_r <= S_RD;
              end
              OP_MEDIAN: begin
                if (tot_r == 32'd0) begin
                  stat_r <= ST_EMPTY; st_r <= S_OUT;
                end else begin
                  addr_r  <= '0;
                  idx_r   <= '0;
                  cum_r   <= '0;
                  lo_ok_r <= 1'b0;
                  rlo_r   <= tot_r[0] ? ({1'b0, tot_r} >> 1) + 33'd1
                                      : ({1'b0, tot_r} >> 1);
                  rhi_r   <= ({1'b0, tot_r} >> 1) + 33'd1;
                  st_r    <= S_RD;
                end
              end
              OP_CLEAR: begin
                addr_r <= '0;
                stat_r <= ST_FULL;
                st_r   <= S_CLR;
              end
              default: st_r <= S_OUT;
            endcase
          end
        end
        // read latency slot
        S_RD: st_r <= (cmd_r.op == OP_INSERT) ? S_WR : S_SCAN;
        S_WR: begin
          tot_r <= tot_r + 32'd1;
          if ($signed(cmd_r.value) < $signed(min_r)) min_r <= cmd_r.value;
          if ($signed(cmd_r.value) > $signed(max_r)) max_r <= cmd_r.value;
          st_r <= S_OUT;
        end
        // each bin is read in S_RD, then accumulated here
        S_SCAN: begin
          cum_r <= cum_n;
          if (!lo_ok_r && (cum_n >= rlo_r || last)) begin
            lo_r <= idx_r; lo_ok_r <= 1'b1;
          end
          if (cum_n >= rhi_r || last) begin
            med_r <= 17'({1'b0, (lo_ok_r ? lo_r : idx_r)}) + 17'({1'b0, idx_r}) +
                     {lowest_r, 1'b0};
            st_r <= S_OUT;
          end else begin
            idx_r  <= idx_r + 1'b1;
            addr_r <= addr_r + AW'(1);
            st_r   <= S_RD;
          end
        end
        S_OUT: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            stat_r <= (stat_r == ST_FULL && cmd_r.op == OP_CLEAR) ? ST_DONE : stat_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop while working");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_fire)
    $past(tot_r) == 32'hFFFF_FFFF && $past(st_r) != S_CLR |-> tot_r != 32'd0)
    else $error("total wrapped");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_fire)
    ov_r && !out_tready |=> ov_r) else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ rtl/histogram_median_tracker_unit.sv @@
// Top level of the histogram median tracker.
// Insert goes S_RD, S_WR, S_OUT; out of window, full, empty and no-op go straight to S_OUT.
// Median: S_RD and S_SCAN per bin up to the median bin, then S_OUT. Clear: S_CLR, then S_OUT.
// Throughput: one item in the back end at a time; the next starts after the result transfer.
// Reset (synchronous, active low) and any configuration write start a sweep that zeroes
// the bins; the two-entry queue keeps taking input until it fills.
`default_nettype none
module histogram_median_tracker_unit import hmt_pkg::*; #(
  parameter int BINS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // value
  input  wire logic [1:0]   in_tuser,   // operation
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [87:0]       out_tdata,  // median_twice, total_count, smallest, largest
  output logic [1:0]        out_tuser,  // status
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data
);
  logic [15:0] lowest_r;
  logic [10:0] bincnt_r;
  logic [16:0] used_bins;
  logic [17:0] top_w;
  logic [15:0] wtop;
  logic        cfg_fire, q_valid, q_pop;
  cmd_t        q_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  // clamp bin count into 1..BINS
  assign used_bins = (bincnt_r == 11'd0) ? 17'd1 :
                     ({6'd0, bincnt_r} > 17'(BINS)) ? 17'(BINS) : {6'd0, bincnt_r};
  assign top_w = 18'($signed({{2{lowest_r[15]}}, lowest_r}) + $signed({1'b0, used_bins}) -
                     18'sd1);
  assign wtop  = (!top_w[17] && (top_w[16] || top_w[15])) ? 16'h7FFF : top_w[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= '0;
      bincnt_r <= 11'd1024;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_LOWEST) lowest_r <= cfg_data;
      else bincnt_r <= cfg_data[10:0];
    end
  end

  hmt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid),
    .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .lowest_r(lowest_r), .used_bins(used_bins),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  hmt_back #(.BINS(BINS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .cfg_fire(cfg_fire), .lowest_r(lowest_r), .used_bins(used_bins),
    .wtop(wtop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );
endmodule
`default_nettype wire

@@ sim/histogram_median_tracker_unit_tb.sv @@
// Self-checking testbench for the histogram median tracker: random stream traffic, scoreboard.
module histogram_median_tracker_unit_tb;
  import hmt_pkg::*;

  localparam int NBINS = 1024;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    op_t         op;
    logic [15:0] value;
  } sample_cmd_t;

  typedef struct {
    status_t            status;
    logic signed [16:0] median_twice;
    logic [31:0]        total;
    logic [15:0]        smallest;
    logic [15:0]        largest;
  } stats_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [15:0]   in_tdata = '0;     // value
  logic [1:0]    in_tuser = '0;     // operation
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [87:0]   out_tdata;         // median_twice, total_count, smallest, largest
  logic [1:0]    out_tuser;         // status
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = 1'b0;
  logic [15:0]   cfg_data = '0;

  histogram_median_tracker_unit #(.BINS(NBINS)) u_dut (.*);

  always #5 clk = ~clk;

  // Predicted state of the histogram
  logic [31:0]        hist_bins [NBINS];
  logic [31:0]        hist_total;
  logic signed [15:0] hist_min;
  logic signed [15:0] hist_max;
  logic signed [15:0] win_low;
  logic [10:0]        win_bins;

  sample_cmd_t pending_cmds[$];
  stats_t      expected_stats[$];
  int          mismatches = 0;
  bit          test_done = 1'b0;
  int          cycles = 0;

  function automatic int bins_used();
    if (win_bins == 0) return 1;
    if (win_bins > NBINS) return NBINS;
    return win_bins;
  endfunction

  function automatic int window_top();
    int top;
    top = win_low + bins_used() - 1;
    return (top > 32767) ? 32767 : top;
  endfunction

  function automatic void clear_hist();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_total = '0;
    hist_min = 16'(window_top());
    hist_max = win_low;
  endfunction

  // Bin holding the element of the given 1-based rank
  function automatic int bin_of_rank(longint rank);
    longint cum;
    cum = 0;
    for (int i = 0; i < bins_used(); i++) begin
      cum += hist_bins[i];
      if (cum >= rank) return i;
    end
    return bins_used() - 1;
  endfunction

  function automatic stats_t apply_cmd(sample_cmd_t c);
    stats_t r;
    int off, lo, hi;
    longint n;
    r.status = ST_DONE;
    r.median_twice = '0;
    case (c.op)
      OP_INSERT: begin
        off = int'($signed(c.value)) - int'(win_low);
        if (off < 0 || off >= bins_used()) r.status = ST_OUTW;
        else if (hist_total == 32'hFFFF_FFFF) r.status = ST_FULL;
        else begin
          hist_bins[off]++;
          hist_total++;
          if ($signed(c.value) < hist_min) hist_min = c.value;
          if ($signed(c.value) > hist_max) hist_max = c.value;
        end
      end
      OP_MEDIAN: begin
        if (hist_total == 0) r.status = ST_EMPTY;
        else begin
          n = hist_total;
          if (n % 2 == 1) begin
            lo = bin_of_rank(n / 2 + 1);
            hi = lo;
          end else begin
            lo = bin_of_rank(n / 2);
            hi = bin_of_rank(n / 2 + 1);
          end
          r.median_twice = 17'(lo + hi + 2 * int'(win_low));
        end
      end
      OP_CLEAR: clear_hist();
      default: ;
    endcase
    r.total = hist_total;
    r.smallest = hist_min;
    r.largest = hist_max;
    return r;
  endfunction

  // Driver: bursts with random gaps; predicts on every input transfer
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_stats.push_back(apply_cmd('{op_t'(in_tuser), in_tdata}));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          sample_cmd_t c;
          c = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.op;
          in_tdata <= c.value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: modes change every so often
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= ~out_tready;
    endcase
  end

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", out_tdata[80:0]);
      end else begin
        stats_t e;
        e = expected_stats.pop_front();
        if (out_tuser !== e.status || out_tdata[16:0] !== e.median_twice ||
            out_tdata[48:17] !== e.total || out_tdata[64:49] !== e.smallest ||
            out_tdata[80:65] !== e.largest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d med2=%0d tot=%0d min=%0d max=%0d, got st=%0d med2=%0d tot=%0d min=%0d max=%0d",
              e.status, e.median_twice, e.total, $signed(e.smallest), $signed(e.largest),
              out_tuser, $signed(out_tdata[16:0]), out_tdata[48:17],
              $signed(out_tdata[64:49]), $signed(out_tdata[80:65]));
        end
      end
    end
  end

  // Register write transfer updates the predicted window
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      if (cfg_index == CFG_LOWEST) win_low = cfg_data;
      else win_bins = cfg_data[10:0];
      clear_hist();
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT && !test_done) begin
      $display("histogram_median_tracker_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (pending_cmds.size() == 0 && expected_stats.size() == 0);
    @(posedge clk);
    wait (!in_tvalid && expected_stats.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    wait (!cfg_valid);
  endtask

  task automatic push_cmd(op_t op, int value);
    pending_cmds.push_back('{op, 16'(value)});
  endtask

  // Random phase: mostly in-window inserts, some medians, rare clears and no-ops
  task automatic random_phase(int count);
    int r, v;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) == 0) v = $signed(16'($urandom));
        else v = int'(win_low) + $urandom_range(0, bins_used() - 1);
        push_cmd(OP_INSERT, v);
      end else if (r < 92) push_cmd(OP_MEDIAN, $urandom);
      else if (r < 96) push_cmd(OP_CLEAR, $urandom);
      else push_cmd(OP_NOP, $urandom);
    end
  endtask

  initial begin
    win_low = '0;
    win_bins = 11'(NBINS);
    clear_hist();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    // Directed: default window, edges, empty median, odd and even counts
    push_cmd(OP_MEDIAN, 0);
    push_cmd(OP_INSERT, -32768);
    push_cmd(OP_INSERT, 32767);
    push_cmd(OP_INSERT, -1);
    push_cmd(OP_INSERT, 1024);
    push_cmd(OP_INSERT, 1023);
    push_cmd(OP_MEDIAN, 0);
    push_cmd(OP_INSERT, 0);
    push_cmd(OP_MEDIAN, 0);
    push_cmd(OP_INSERT, 500);
    push_cmd(OP_INSERT, 500);
    push_cmd(OP_MEDIAN, 0);
    push_cmd(OP_NOP, 16'hFFFF);
    push_cmd(OP_CLEAR, 16'h5555);
    push_cmd(OP_MEDIAN, 16'hAAAA);
    wait_idle();

    // Lowest window with one bin
    write_reg(CFG_LOWEST, 16'h8000);
    write_reg(CFG_BINCNT, 11'd1);
    push_cmd(OP_INSERT, -32768);
    push_cmd(OP_INSERT, -32767);
    push_cmd(OP_MEDIAN, 0);
    random_phase(150);
    wait_idle();

    // Window top past the largest value saturates
    write_reg(CFG_LOWEST, 16'h7F00);
    write_reg(CFG_BINCNT, 11'd1024);
    push_cmd(OP_INSERT, 32767);
    push_cmd(OP_INSERT, 32512);
    push_cmd(OP_MEDIAN, 0);
    random_phase(150);
    wait_idle();

    // Zero bin count acts as one bin
    write_reg(CFG_LOWEST, -16'sd5);
    write_reg(CFG_BINCNT, 11'd0);
    push_cmd(OP_INSERT, -5);
    push_cmd(OP_INSERT, -4);
    random_phase(100);
    wait_idle();

    // Oversized bin count acts as the full store
    write_reg(CFG_BINCNT, 11'h7FF);
    write_reg(CFG_LOWEST, 16'd100);
    random_phase(150);
    wait_idle();

    // Small windows carry most of the random traffic
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_LOWEST, 16'($urandom));
      write_reg(CFG_BINCNT, 11'($urandom_range(2, 64)));
      random_phase(170);
      wait_idle();
    end

    wait (pending_cmds.size() == 0 && expected_stats.size() == 0);
    repeat (3000) @(posedge clk);
    test_done = 1'b1;
    if (mismatches == 0 && expected_stats.size() == 0)
      $display("histogram_median_tracker_unit_tb: PASS");
    else
      $display("histogram_median_tracker_unit_tb: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
rtl/hmt_pkg.sv
rtl/hmt_front.sv
rtl/hmt_back.sv
rtl/histogram_median_tracker_unit.sv
sim/histogram_median_tracker_unit_tb.sv
